FILE: src/rtp_pkg.sv
package rtp_pkg;

   // cordic datapath widths, fixed by the normalisation to bit 60
   localparam int XW = 63;
   localparam int ZW = 64;
   localparam int NORM_POS = 61;
   localparam int CORDIC_STEPS = 61;

   // hypotenuse fraction bits
   localparam int HYP_FRAC = 8;

   // per-stage control
   typedef struct packed {
      logic valid;
      logic swap;
      logic degen;
   } ctl_type;

   // cordic vector and angle accumulator
   typedef struct packed {
      logic [XW-1:0] x;
      logic [XW-1:0] y;
      logic          ypos;
      logic [ZW-1:0] z;
   } crd_type;

endpackage

FILE: src/rtp_norm.sv
module rtp_norm
   import rtp_pkg::*;
#(
   parameter int LEG_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             valid_i,
   input  logic [LEG_BITS-1:0]              leg_a_i,
   input  logic [LEG_BITS-1:0]              leg_b_i,
   output ctl_type                          ctl_o,
   output crd_type                          crd_o,
   output logic [2*(LEG_BITS+HYP_FRAC+1)-1:0] rad_o
);

   localparam int HB = LEG_BITS + HYP_FRAC + 1;
   localparam int RW = 2 * HB;
   localparam int SQW = 2 * LEG_BITS + 1;
   localparam int NSTEP = $clog2(LEG_BITS);
   localparam int SHL = NORM_POS - LEG_BITS;

   ctl_type                ctl1_ff, ctl1_in, ctl2_ff;
   logic [2*LEG_BITS-1:0]  aa_ff, bb_ff;
   logic [LEG_BITS-1:0]    mv_ff, sv_ff, mv_in, sv_in;
   crd_type                crd_ff, crd_in;
   logic [RW-1:0]          rad_ff, rad_in;
   logic [SQW-1:0]         sum;

   // order the legs and shift the longer one up to its top bit
   always_comb begin
      ctl1_in.valid = valid_i;
      ctl1_in.degen = (leg_a_i == '0) && (leg_b_i == '0);
      ctl1_in.swap  = leg_a_i > leg_b_i;
      mv_in = ctl1_in.swap ? leg_a_i : leg_b_i;
      sv_in = ctl1_in.swap ? leg_b_i : leg_a_i;
      for (int k = NSTEP - 1; k >= 0; k--) begin
         if ((mv_in >> (LEG_BITS - (1 << k))) == '0) begin
            mv_in = mv_in << (1 << k);
            sv_in = sv_in << (1 << k);
         end
      end
   end

   // sum of squares and the starting vector
   always_comb begin
      sum = SQW'(aa_ff) + SQW'(bb_ff);
      rad_in = RW'(sum) << (2 * HYP_FRAC);
      crd_in.x = XW'(mv_ff) << SHL;
      crd_in.y = XW'(sv_ff) << SHL;
      crd_in.ypos = 1'b1;
      crd_in.z = '0;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
      end
   end

   // data
   always_ff @(posedge clock) begin
      if (adv) begin
         aa_ff  <= (2*LEG_BITS)'(leg_a_i) * (2*LEG_BITS)'(leg_a_i);
         bb_ff  <= (2*LEG_BITS)'(leg_b_i) * (2*LEG_BITS)'(leg_b_i);
         mv_ff  <= mv_in;
         sv_ff  <= sv_in;
         crd_ff <= crd_in;
         rad_ff <= rad_in;
      end
   end

   assign ctl_o = ctl2_ff;
   assign crd_o = crd_ff;
   assign rad_o = rad_ff;

endmodule

FILE: src/rtp_cell.sv
module rtp_cell
   import rtp_pkg::*;
#(
   parameter int STEP = 1,
   parameter bit ROOT_ON = 1'b1,
   parameter int HYP_BITS = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  ctl_type               ctl_i,
   input  crd_type               crd_i,
   input  logic [2*HYP_BITS-1:0] rad_i,
   input  logic [HYP_BITS+1:0]   rem_i,
   input  logic [HYP_BITS-1:0]   root_i,
   output ctl_type               ctl_o,
   output crd_type               crd_o,
   output logic [2*HYP_BITS-1:0] rad_o,
   output logic [HYP_BITS+1:0]   rem_o,
   output logic [HYP_BITS-1:0]   root_o
);

   localparam int RW = 2 * HYP_BITS;
   localparam int RMW = HYP_BITS + 2;
   localparam int SHW = HYP_BITS + 4;

   // 2^(62-e) in radians, zero once the term drops below one lsb
   function automatic logic [63:0] pw(input int e);
      logic [63:0] r;
      r = (e > 62) ? 64'd0 : (64'd1 << (62 - e));
      return r;
   endfunction

   // atan(2^-STEP) as a truncated series
   localparam logic [63:0] ATAN =
        pw(STEP*1)/64'd1   - pw(STEP*3)/64'd3   + pw(STEP*5)/64'd5   - pw(STEP*7)/64'd7
      + pw(STEP*9)/64'd9   - pw(STEP*11)/64'd11 + pw(STEP*13)/64'd13 - pw(STEP*15)/64'd15
      + pw(STEP*17)/64'd17 - pw(STEP*19)/64'd19 + pw(STEP*21)/64'd21 - pw(STEP*23)/64'd23
      + pw(STEP*25)/64'd25 - pw(STEP*27)/64'd27 + pw(STEP*29)/64'd29 - pw(STEP*31)/64'd31
      + pw(STEP*33)/64'd33 - pw(STEP*35)/64'd35 + pw(STEP*37)/64'd37 - pw(STEP*39)/64'd39
      + pw(STEP*41)/64'd41 - pw(STEP*43)/64'd43 + pw(STEP*45)/64'd45 - pw(STEP*47)/64'd47
      + pw(STEP*49)/64'd49 - pw(STEP*51)/64'd51 + pw(STEP*53)/64'd53 - pw(STEP*55)/64'd55
      + pw(STEP*57)/64'd57 - pw(STEP*59)/64'd59 + pw(STEP*61)/64'd61;

   ctl_type        ctl_ff;
   crd_type        crd_ff, crd_in;
   logic [RW-1:0]  rad_ff, rad_in;
   logic [RMW-1:0] rem_ff, rem_in;
   logic [HYP_BITS-1:0] root_ff, root_in;
   logic [XW-1:0]  xs, ys;
   logic [SHW-1:0] rem_sh, trial;

   // one cordic vectoring rotation, residual kept as sign and magnitude
   always_comb begin
      xs = crd_i.x >> STEP;
      ys = crd_i.y >> STEP;
      crd_in.x = crd_i.x + ys;
      crd_in.z = crd_i.ypos ? (crd_i.z + ATAN) : (crd_i.z - ATAN);
      if (crd_i.y >= xs) begin
         crd_in.y = crd_i.y - xs;
         crd_in.ypos = crd_i.ypos;
      end else begin
         crd_in.y = xs - crd_i.y;
         crd_in.ypos = ~crd_i.ypos;
      end
   end

   // one digit of the restoring square root
   always_comb begin
      rem_sh = {rem_i, rad_i[RW-1 -: 2]};
      trial = SHW'({root_i, 2'b01});
      rad_in = rad_i;
      rem_in = rem_i;
      root_in = root_i;
      if (ROOT_ON) begin
         rad_in = rad_i << 2;
         if (rem_sh >= trial) begin
            rem_in = RMW'(rem_sh - trial);
            root_in = {root_i[HYP_BITS-2:0], 1'b1};
         end else begin
            rem_in = RMW'(rem_sh);
            root_in = {root_i[HYP_BITS-2:0], 1'b0};
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_i;
      end
   end

   // data
   always_ff @(posedge clock) begin
      if (adv) begin
         crd_ff  <= crd_in;
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign crd_o  = crd_ff;
   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

FILE: src/rtp_scale.sv
module rtp_scale
   import rtp_pkg::*;
#(
   parameter int HYP_BITS = 25,
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  ctl_type                      ctl_i,
   input  logic [ZW-1:0]                z_i,
   input  logic [HYP_BITS+1:0]          rem_i,
   input  logic [HYP_BITS-1:0]          root_i,
   output logic                         valid_o,
   output logic [HYP_BITS-1:0]          hyp_o,
   output logic [ANGLE_FRAC_BITS+6:0]   angle_a_o,
   output logic [ANGLE_FRAC_BITS+6:0]   angle_b_o,
   output logic                         degen_o
);

   localparam int AB = ANGLE_FRAC_BITS + 7;
   localparam int SHR = 54 - ANGLE_FRAC_BITS;
   localparam logic [63:0] RND = 64'd1 << (SHR - 1);
   localparam logic [AB-1:0] NINETY = AB'(90) << ANGLE_FRAC_BITS;
   // 180/pi with 56 fraction bits, as two halves
   localparam logic [31:0] DEG_HI = 32'h394BB834;
   localparam logic [31:0] DEG_LO = 32'hC783EF71;

   ctl_type             ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff;
   logic [62:0]         zc;
   logic [63:0]         p00_ff, p01_ff;
   logic [62:0]         p10_ff, p11_ff;
   logic [64:0]         mid_ff;
   logic [63:0]         lo_ff, hi_ff, top_ff;
   logic [127:0]        full;
   logic [AB-1:0]       ang_ff, ang_a_ff, ang_b_ff, oth;
   logic [HYP_BITS-1:0] hyp1_ff, hyp2_ff, hyp3_ff, hyp4_ff, hyp5_ff, hyp_in;

   // clamp the angle, round the root, add the partial products, form the complementary angle
   always_comb begin
      zc = z_i[ZW-1] ? 63'd0 : z_i[62:0];
      hyp_in = root_i + HYP_BITS'((HYP_BITS+2)'(root_i) < rem_i);
      full = {hi_ff, lo_ff} + (128'(mid_ff) << 32);
      oth = NINETY - ang_ff;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= ctl_i;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
         ctl5_ff <= ctl4_ff;
      end
   end

   // partial products, their sum, rounding and the complementary angle
   always_ff @(posedge clock) begin
      if (adv) begin
         p00_ff <= 64'(zc[31:0]) * 64'(DEG_LO);
         p01_ff <= 64'(zc[31:0]) * 64'(DEG_HI);
         p10_ff <= 63'(zc[62:32]) * 63'(DEG_LO);
         p11_ff <= 63'(zc[62:32]) * 63'(DEG_HI);
         hyp1_ff <= hyp_in;

         mid_ff <= 65'(p01_ff) + 65'(p10_ff);
         lo_ff <= p00_ff;
         hi_ff <= 64'(p11_ff);
         hyp2_ff <= hyp1_ff;

         top_ff <= full[127:64];
         hyp3_ff <= hyp2_ff;

         ang_ff <= AB'((top_ff + RND) >> SHR);
         hyp4_ff <= hyp3_ff;

         if (ctl4_ff.degen) begin
            ang_a_ff <= '0;
            ang_b_ff <= '0;
         end else if (ctl4_ff.swap) begin
            ang_a_ff <= oth;
            ang_b_ff <= ang_ff;
         end else begin
            ang_a_ff <= ang_ff;
            ang_b_ff <= oth;
         end
         hyp5_ff <= hyp4_ff;
      end
   end

   assign valid_o   = ctl5_ff.valid;
   assign hyp_o     = hyp5_ff;
   assign angle_a_o = ang_a_ff;
   assign angle_b_o = ang_b_ff;
   assign degen_o   = ctl5_ff.degen;

endmodule

FILE: src/right_triangle_polar_core.sv
// Rectangular-to-polar converter for a right triangle: takes the two integer legs and
// returns the hypotenuse (8 fraction bits, rounded) and the two angles in degrees
// (ANGLE_FRAC_BITS fraction bits, rounded, summing to exactly 90 for nonzero legs).
// Both legs zero gives zeros with degenerate set. One word is taken every cycle while
// the skid is free; a word passes through 2 front stages, 61 cordic cells, 5 scaling
// stages and the output register. Most of the pipeline is the 61-cell cordic chain,
// which also carries the square root in its first LEG_BITS+9 cells. The output holds
// one word plus a one-word skid, so input stalls only once the skid fills.
module right_triangle_polar_core
   import rtp_pkg::*;
#(
   parameter int LEG_BITS = 16,
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [LEG_BITS-1:0]          req_leg_a,
   input  logic [LEG_BITS-1:0]          req_leg_b,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [LEG_BITS+8:0]          rsp_hyp_len,
   output logic [ANGLE_FRAC_BITS+6:0]   rsp_angle_a,
   output logic [ANGLE_FRAC_BITS+6:0]   rsp_angle_b,
   output logic                         rsp_degenerate
);

   localparam int HB = LEG_BITS + HYP_FRAC + 1;
   localparam int RW = 2 * HB;
   localparam int AB = ANGLE_FRAC_BITS + 7;

   logic adv;

   ctl_type          c_ctl  [CORDIC_STEPS+1];
   crd_type          c_crd  [CORDIC_STEPS+1];
   logic [RW-1:0]    c_rad  [CORDIC_STEPS+1];
   logic [HB+1:0]    c_rem  [CORDIC_STEPS+1];
   logic [HB-1:0]    c_root [CORDIC_STEPS+1];

   logic             p_valid, p_degen;
   logic [HB-1:0]    p_hyp;
   logic [AB-1:0]    p_ang_a, p_ang_b;

   logic             out_valid_ff, skid_valid_ff;
   logic [HB-1:0]    out_hyp_ff, skid_hyp_ff;
   logic [AB-1:0]    out_ang_a_ff, out_ang_b_ff, skid_ang_a_ff, skid_ang_b_ff;
   logic             out_degen_ff, skid_degen_ff;

   // whole pipeline moves while the skid word is free
   assign adv = ~skid_valid_ff;
   assign req_ready = adv;

   // leg ordering, normalisation and sum of squares
   rtp_norm #(
      .LEG_BITS(LEG_BITS)
   ) u_norm (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .valid_i (req_valid),
      .leg_a_i (req_leg_a),
      .leg_b_i (req_leg_b),
      .ctl_o   (c_ctl[0]),
      .crd_o   (c_crd[0]),
      .rad_o   (c_rad[0])
   );

   assign c_rem[0]  = '0;
   assign c_root[0] = '0;

   // cordic and square root cells
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      rtp_cell #(
         .STEP     (k + 1),
         .ROOT_ON  (k < HB),
         .HYP_BITS (HB)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ctl_i  (c_ctl[k]),
         .crd_i  (c_crd[k]),
         .rad_i  (c_rad[k]),
         .rem_i  (c_rem[k]),
         .root_i (c_root[k]),
         .ctl_o  (c_ctl[k+1]),
         .crd_o  (c_crd[k+1]),
         .rad_o  (c_rad[k+1]),
         .rem_o  (c_rem[k+1]),
         .root_o (c_root[k+1])
      );
   end

   // radians to degrees and final assembly
   rtp_scale #(
      .HYP_BITS        (HB),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .ctl_i     (c_ctl[CORDIC_STEPS]),
      .z_i       (c_crd[CORDIC_STEPS].z),
      .rem_i     (c_rem[CORDIC_STEPS]),
      .root_i    (c_root[CORDIC_STEPS]),
      .valid_o   (p_valid),
      .hyp_o     (p_hyp),
      .angle_a_o (p_ang_a),
      .angle_b_o (p_ang_b),
      .degen_o   (p_degen)
   );

   // output word with one-word skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (p_valid) begin
         if (out_valid_ff && !rsp_ready) begin
            skid_valid_ff <= 1'b1;
         end
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_hyp_ff   <= skid_hyp_ff;
            out_ang_a_ff <= skid_ang_a_ff;
            out_ang_b_ff <= skid_ang_b_ff;
            out_degen_ff <= skid_degen_ff;
         end
      end else if (p_valid) begin
         if (out_valid_ff && !rsp_ready) begin
            skid_hyp_ff   <= p_hyp;
            skid_ang_a_ff <= p_ang_a;
            skid_ang_b_ff <= p_ang_b;
            skid_degen_ff <= p_degen;
         end else begin
            out_hyp_ff   <= p_hyp;
            out_ang_a_ff <= p_ang_a;
            out_ang_b_ff <= p_ang_b;
            out_degen_ff <= p_degen;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hyp_len    = out_hyp_ff;
   assign rsp_angle_a    = out_ang_a_ff;
   assign rsp_angle_b    = out_ang_b_ff;
   assign rsp_degenerate = out_degen_ff;

endmodule

FILE: verif/tb_right_triangle_polar_core.sv
module tb_right_triangle_polar_core;
   import rtp_pkg::*;

   localparam int LEG_BITS = 16;
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int HYP_W = LEG_BITS + 9;
   localparam int ANG_W = ANGLE_FRAC_BITS + 7;
   localparam int PIPE_DEPTH = 69;
   localparam int STALL_LIMIT = 5000;
   localparam int RAD_Q = 62;
   localparam logic [63:0] DEG_PER_RAD_Q56 = 64'h394BB834C783EF71;
   localparam logic [63:0] NINETY_DEG = 64'd90 << ANGLE_FRAC_BITS;
   localparam int SWEEP_WORDS = 190;

   // one expected result word, with the legs that caused it
   typedef struct packed {
      logic [LEG_BITS-1:0] leg_a;
      logic [LEG_BITS-1:0] leg_b;
      logic [HYP_W-1:0]    hyp;
      logic [ANG_W-1:0]    ang_a;
      logic [ANG_W-1:0]    ang_b;
      logic                degen;
   } polar_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [LEG_BITS-1:0] req_leg_a = '0;
   logic [LEG_BITS-1:0] req_leg_b = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [HYP_W-1:0]    rsp_hyp_len;
   logic [ANG_W-1:0]    rsp_angle_a;
   logic [ANG_W-1:0]    rsp_angle_b;
   logic                rsp_degenerate;

   polar_word_type pending_words[$];
   int          mismatch_count = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          quiet_cycles = 0;

   right_triangle_polar_core #(
      .LEG_BITS(LEG_BITS),
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_leg_a(req_leg_a),
      .req_leg_b(req_leg_b),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hyp_len(rsp_hyp_len),
      .rsp_angle_a(rsp_angle_a),
      .rsp_angle_b(rsp_angle_b),
      .rsp_degenerate(rsp_degenerate)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // atan(2^-i) in radians, q62, from the truncated taylor series
   function automatic logic [63:0] atan_pow2_q62(int unsigned i);
      logic [63:0] sum;
      logic [63:0] term;
      int unsigned k;
      int unsigned e;
      sum = '0;
      for (k = 0; k < 64; k++) begin
         e = i * (2 * k + 1);
         if (e > RAD_Q) break;
         term = (64'd1 << (RAD_Q - e)) / 64'(2 * k + 1);
         if (k[0]) sum = sum - term;
         else sum = sum + term;
      end
      return sum;
   endfunction

   // sqrt((a*a+b*b)*2^16), rounded to nearest
   function automatic logic [HYP_W-1:0] hyp_q8(logic [LEG_BITS-1:0] a, logic [LEG_BITS-1:0] b);
      logic [63:0] rad;
      logic [63:0] root;
      logic [63:0] rem;
      logic [63:0] trial;
      int p;
      rad = (64'(a) * 64'(a) + 64'(b) * 64'(b)) << 16;
      root = '0;
      rem = '0;
      for (p = 31; p >= 0; p--) begin
         rem = (rem << 2) | ((rad >> (2 * p)) & 64'd3);
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      if (rem > root) root = root + 64'd1;
      return root[HYP_W-1:0];
   endfunction

   // angle opposite the shorter leg, degrees, rounded at the angle fraction
   function automatic logic [63:0] shorter_angle(logic [63:0] s, logic [63:0] m);
      logic [63:0]        x;
      logic [63:0]        ymag;
      logic [63:0]        xs;
      logic [63:0]        ys;
      logic [63:0]        t;
      logic [63:0]        hi;
      logic [127:0]       prod;
      logic signed [63:0] z;
      logic signed [63:0] step;
      logic               ypos;
      int                 len;
      int                 i;
      len = 0;
      t = m;
      while (t != 0) begin
         len++;
         t = t >> 1;
      end
      x = m << (61 - len);
      ymag = s << (61 - len);
      ypos = 1'b1;
      z = '0;
      // vectoring with the residual kept as sign and magnitude
      for (i = 1; i <= 61; i++) begin
         xs = x >> i;
         ys = ymag >> i;
         step = $signed(atan_pow2_q62(i));
         x = x + ys;
         if (ypos) z = z + step;
         else z = z - step;
         if (ymag >= xs) begin
            ymag = ymag - xs;
         end else begin
            ymag = xs - ymag;
            ypos = !ypos;
         end
      end
      if (z < 0) z = '0;
      prod = {64'd0, z} * {64'd0, DEG_PER_RAD_Q56};
      hi = prod[127:64] + (64'd1 << (53 - ANGLE_FRAC_BITS));
      return hi >> (54 - ANGLE_FRAC_BITS);
   endfunction

   function automatic polar_word_type polar_of(logic [LEG_BITS-1:0] a, logic [LEG_BITS-1:0] b);
      polar_word_type w;
      logic [63:0] ang;
      w = '0;
      w.leg_a = a;
      w.leg_b = b;
      if (a == 0 && b == 0) begin
         w.degen = 1'b1;
         return w;
      end
      w.hyp = hyp_q8(a, b);
      // equal legs take the cordic angle on the a side
      if (a <= b) begin
         ang = shorter_angle(64'(a), 64'(b));
         w.ang_a = ang[ANG_W-1:0];
         w.ang_b = 23'(NINETY_DEG - ang);
      end else begin
         ang = shorter_angle(64'(b), 64'(a));
         w.ang_b = ang[ANG_W-1:0];
         w.ang_a = 23'(NINETY_DEG - ang);
      end
      return w;
   endfunction

   // offer one word, idling first at the current rate
   task automatic send_legs(input logic [LEG_BITS-1:0] a, input logic [LEG_BITS-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_leg_a <= a;
      req_leg_b <= b;
      do @(posedge clock); while (!req_ready);
      pending_words.push_back(polar_of(a, b));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // legs drawn from a mix of shapes that stress normalisation and the cordic
   task automatic pick_legs(output logic [LEG_BITS-1:0] a, output logic [LEG_BITS-1:0] b);
      logic [LEG_BITS-1:0] p;
      logic [LEG_BITS-1:0] q;
      int d;
      p = 16'($urandom_range(65535));
      q = 16'($urandom_range(65535));
      case ($urandom_range(9))
         0, 1, 2, 3: ;
         4: begin
            p = 16'($urandom_range(255));
            q = 16'($urandom_range(255));
         end
         5: q = '0;
         6: q = p;
         7: begin
            d = $urandom_range(4);
            q = (int'(p) + d > 65535) ? 16'(int'(p) - d) : 16'(int'(p) + d);
         end
         8: q = 16'($urandom_range(15));
         default: begin
            p = p >> $urandom_range(15);
            q = q >> $urandom_range(15);
         end
      endcase
      if ($urandom_range(1)) begin
         a = p;
         b = q;
      end else begin
         a = q;
         b = p;
      end
   endtask

   task automatic test_leg_extremes();
      send_legs(16'd0, 16'd65535);
      send_legs(16'd65535, 16'd0);
      send_legs(16'd65535, 16'd65535);
      send_legs(16'd1, 16'd65535);
      send_legs(16'd65535, 16'd1);
      send_legs(16'd1, 16'd1);
      send_legs(16'h8000, 16'h7FFF);
      send_legs(16'hAAAA, 16'h5555);
      send_legs(16'h5555, 16'hAAAA);
      send_legs(16'd65534, 16'd65535);
   endtask

   task automatic test_special_cases();
      // both legs zero
      send_legs(16'd0, 16'd0);
      // one leg zero
      send_legs(16'd0, 16'd1);
      send_legs(16'd1, 16'd0);
      // equal legs
      send_legs(16'h8000, 16'h8000);
      send_legs(16'd77, 16'd77);
      // exact hypotenuse, then inexact ones and both legs zero again
      send_legs(16'd3, 16'd4);
      send_legs(16'd4, 16'd3);
      send_legs(16'd1, 16'd2);
      send_legs(16'd2, 16'd1);
      send_legs(16'd12345, 16'd54321);
      send_legs(16'd0, 16'd0);
   endtask

   task automatic test_drain_pause();
      logic [LEG_BITS-1:0] a;
      logic [LEG_BITS-1:0] b;
      int n;
      idle_pct = 0;
      stall_pct = 25;
      for (n = 0; n < 30; n++) begin
         pick_legs(a, b);
         send_legs(a, b);
         if (n == 14) wait_drained();
      end
   endtask

   task automatic test_random_sweep(input int sender_idle, input int receiver_stall);
      logic [LEG_BITS-1:0] a;
      logic [LEG_BITS-1:0] b;
      int n;
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      for (n = 0; n < SWEEP_WORDS; n++) begin
         pick_legs(a, b);
         send_legs(a, b);
      end
   endtask

   // receiver readiness
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // compare each result word with the oldest expectation
   always @(posedge clock) begin
      polar_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word hyp %0d angles %0d %0d degenerate %0d",
                     $time, rsp_hyp_len, rsp_angle_a, rsp_angle_b, rsp_degenerate);
            mismatch_count++;
         end else begin
            w = pending_words.pop_front();
            if (rsp_hyp_len !== w.hyp) begin
               $display("%0t: legs %0d %0d hyp_len expected %0d got %0d",
                        $time, w.leg_a, w.leg_b, w.hyp, rsp_hyp_len);
               mismatch_count++;
            end
            if (rsp_angle_a !== w.ang_a) begin
               $display("%0t: legs %0d %0d angle_a expected %0d got %0d",
                        $time, w.leg_a, w.leg_b, w.ang_a, rsp_angle_a);
               mismatch_count++;
            end
            if (rsp_angle_b !== w.ang_b) begin
               $display("%0t: legs %0d %0d angle_b expected %0d got %0d",
                        $time, w.leg_a, w.leg_b, w.ang_b, rsp_angle_b);
               mismatch_count++;
            end
            if (rsp_degenerate !== w.degen) begin
               $display("%0t: legs %0d %0d degenerate expected %0d got %0d",
                        $time, w.leg_a, w.leg_b, w.degen, rsp_degenerate);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_leg_extremes();
      test_special_cases();
      test_drain_pause();
      test_random_sweep(0, 0);
      test_random_sweep(53, 0);
      test_random_sweep(0, 53);
      test_random_sweep(25, 25);
      wait_drained();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
